// File: rtl/i2crs_pkg.sv
// Shared types, status codes and register constants for the I2C register sync sequencer.
`timescale 1ns / 1ps

package i2crs_pkg;

	// Packed widths of the stream payloads
	localparam int DATA_IN_W  = 56;
	localparam int DATA_OUT_W = 32;

	// Configuration register indexes
	localparam logic [2:0] CFG_SLAVE_ADDR  = 3'd0;
	localparam logic [2:0] CFG_START_DELAY = 3'd1;
	localparam logic [2:0] CFG_CONTROL     = 3'd2;
	localparam logic [2:0] CFG_ILIM_MAX    = 3'd3;
	localparam logic [2:0] CFG_UV_THRESH   = 3'd4;
	localparam logic [2:0] CFG_SCALE_PROT  = 3'd5;
	localparam logic [2:0] CFG_SCALE_NORM  = 3'd6;

	// Configuration reset values
	localparam logic [6:0]  RST_SLAVE_ADDR  = 7'h3B;
	localparam logic [7:0]  RST_START_DELAY = 8'd5;
	localparam logic [15:0] RST_CONTROL     = 16'h4046;
	localparam logic [15:0] RST_ILIM_MAX    = 16'hF000;
	localparam logic [7:0]  RST_UV_THRESH   = 8'h1E;
	localparam logic [7:0]  RST_SCALE_PROT  = 8'd22;
	localparam logic [7:0]  RST_SCALE_NORM  = 8'd20;

	// Master-mode I2C controller status codes
	localparam logic [7:0] ST_START      = 8'h08;
	localparam logic [7:0] ST_RSTART     = 8'h10;
	localparam logic [7:0] ST_SLAW_ACK   = 8'h18;
	localparam logic [7:0] ST_SLAW_NACK  = 8'h20;
	localparam logic [7:0] ST_DATA_ACK   = 8'h28;
	localparam logic [7:0] ST_DATA_NACK  = 8'h30;
	localparam logic [7:0] ST_SLAR_ACK   = 8'h40;
	localparam logic [7:0] ST_SLAR_NACK  = 8'h48;
	localparam logic [7:0] ST_RX_ACK     = 8'h50;
	localparam logic [7:0] ST_RX_NACK    = 8'h58;

	// Converter register addresses and commands
	localparam logic [7:0] REG_CONTROL  = 8'h00;
	localparam logic [7:0] REG_ILIM     = 8'h01;
	localparam logic [7:0] REG_VOUT     = 8'h02;
	localparam logic [7:0] REG_UVLO     = 8'h03;
	localparam logic [7:0] REG_ILIM_MAX = 8'h07;
	localparam logic [7:0] REG_RESET    = 8'hEE;
	localparam logic [7:0] REG_STATUS   = 8'hFF;
	localparam logic [7:0] RESET_CMD    = 8'h80;
	localparam logic [7:0] BYTE_CNT_RD  = 8'hFF;

	// Acknowledge-enable control codes
	localparam logic [1:0] ACK_NONE  = 2'd0;
	localparam logic [1:0] ACK_SET   = 2'd1;
	localparam logic [1:0] ACK_CLEAR = 2'd2;

	// SCL pin control codes
	localparam logic [1:0] SCL_NONE    = 2'd0;
	localparam logic [1:0] SCL_LOW     = 2'd1;
	localparam logic [1:0] SCL_RELEASE = 2'd2;

	// Sequencer phases
	typedef enum logic [3:0] {
		PH_RECOVER   = 4'd0,
		PH_DELAY     = 4'd1,
		PH_INIT_CTRL = 4'd2,
		PH_INIT_ILIM = 4'd3,
		PH_INIT_UV   = 4'd4,
		PH_IDLE      = 4'd5,
		PH_WAIT_RST  = 4'd6,
		PH_WAIT_CTRL = 4'd7,
		PH_WAIT_ILIM = 4'd8,
		PH_WAIT_UV   = 4'd9,
		PH_VOLT_SENT = 4'd10,
		PH_CURR_SENT = 4'd11,
		PH_STAT_READ = 4'd12
	} phase_t;

	// One input item
	typedef struct packed {
		logic        operation;
		logic [7:0]  bus_status;
		logic [7:0]  read_byte;
		logic [15:0] requested_voltage;
		logic [15:0] requested_current;
		logic        overcurrent_enabled;
		logic        scl_level;
		logic        sda_level;
	} item_t;

	// One result item
	typedef struct packed {
		logic       start_request;
		logic       start_clear;
		logic       stop_request;
		logic [1:0] ack_control;
		logic       tx_valid;
		logic [7:0] tx_byte;
		logic [1:0] scl_drive;
		logic       busy_flag;
		logic [7:0] converter_status;
		logic [3:0] phase;
	} result_t;

	// Configuration register file
	typedef struct packed {
		logic [6:0]  slave_address;
		logic [7:0]  startup_delay_ticks;
		logic [15:0] control_word;
		logic [15:0] current_limit_max;
		logic [7:0]  undervoltage_threshold;
		logic [7:0]  current_scale_protected;
		logic [7:0]  current_scale_normal;
	} cfg_t;

endpackage

// File: rtl/i2crs_core.sv
// Sequencer state, configuration registers and combinational step logic.
`timescale 1ns / 1ps

module i2crs_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [2:0]           cfg_index,
	input  logic [15:0]          cfg_data,
	input  logic                 step_en,
	input  i2crs_pkg::item_t     item,
	output i2crs_pkg::result_t   result
);
	import i2crs_pkg::*;

	cfg_t        cfg_q;
	phase_t      phase_q, phase_d;
	logic [7:0]  delay_q, delay_d;
	logic        busy_q, busy_d;
	logic [7:0]  bcount_q, bcount_d;
	logic [7:0]  device_q, device_d;
	logic [7:0]  target_q, target_d;
	logic [7:0]  lo_q, lo_d;
	logic [7:0]  hi_q, hi_d;
	logic [15:0] wvolt_q, wvolt_d;
	logic [15:0] wcurr_q, wcurr_d;
	logic [15:0] svolt_q, svolt_d;
	logic [15:0] scurr_q, scurr_d;
	logic [7:0]  status_q, status_d;

	logic        tick;
	logic        delay_done;
	logic [15:0] volt_calc;
	logic [7:0]  scale;
	logic [23:0] curr_prod;
	logic [15:0] curr_calc;
	logic        curr_diff, volt_diff;
	logic [7:0]  bcount_inc;
	logic        begin_x;
	logic [7:0]  x_reg, x_lo, x_hi;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{RST_SLAVE_ADDR, RST_START_DELAY, RST_CONTROL, RST_ILIM_MAX,
				RST_UV_THRESH, RST_SCALE_PROT, RST_SCALE_NORM};
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_SLAVE_ADDR:  cfg_q.slave_address <= cfg_data[6:0];
				CFG_START_DELAY: cfg_q.startup_delay_ticks <= cfg_data[7:0];
				CFG_CONTROL:     cfg_q.control_word <= cfg_data;
				CFG_ILIM_MAX:    cfg_q.current_limit_max <= cfg_data;
				CFG_UV_THRESH:   cfg_q.undervoltage_threshold <= cfg_data[7:0];
				CFG_SCALE_PROT:  cfg_q.current_scale_protected <= cfg_data[7:0];
				CFG_SCALE_NORM:  cfg_q.current_scale_normal <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// Shared decode: requested values, wrapped at 16 bits
	assign tick       = !item.operation && !busy_q;
	assign delay_done = (delay_q == cfg_q.startup_delay_ticks);
	assign volt_calc  = {item.requested_voltage[14:0], 1'b0};
	assign scale      = item.overcurrent_enabled ? cfg_q.current_scale_protected
		: cfg_q.current_scale_normal;
	assign curr_prod  = {8'd0, item.requested_current} * {16'd0, scale};
	assign curr_calc  = curr_prod[15:0];
	assign curr_diff  = (curr_calc != scurr_q);
	assign volt_diff  = (volt_calc != svolt_q);
	assign bcount_inc = bcount_q + 8'd1;

	// Next phase
	always_comb begin
		phase_d = phase_q;
		if (tick) begin
			unique case (phase_q)
				PH_RECOVER:   if (item.scl_level && item.sda_level) phase_d = PH_DELAY;
				PH_DELAY:     if (delay_done) phase_d = PH_WAIT_RST;
				PH_INIT_CTRL: phase_d = PH_WAIT_CTRL;
				PH_INIT_ILIM: phase_d = PH_WAIT_ILIM;
				PH_INIT_UV:   phase_d = PH_WAIT_UV;
				PH_IDLE: begin
					if (curr_diff)      phase_d = PH_CURR_SENT;
					else if (volt_diff) phase_d = PH_VOLT_SENT;
					else                phase_d = PH_STAT_READ;
				end
				PH_WAIT_RST:  phase_d = PH_INIT_CTRL;
				PH_WAIT_CTRL: phase_d = PH_INIT_ILIM;
				PH_WAIT_ILIM: phase_d = PH_INIT_UV;
				PH_WAIT_UV, PH_VOLT_SENT, PH_CURR_SENT, PH_STAT_READ: phase_d = PH_IDLE;
				default: ;
			endcase
		end
	end

	// Data path, bus commands and result fields
	always_comb begin
		delay_d  = delay_q;
		busy_d   = busy_q;
		bcount_d = bcount_q;
		device_d = device_q;
		target_d = target_q;
		lo_d     = lo_q;
		hi_d     = hi_q;
		wvolt_d  = wvolt_q;
		wcurr_d  = wcurr_q;
		svolt_d  = svolt_q;
		scurr_d  = scurr_q;
		status_d = status_q;
		begin_x  = 1'b0;
		x_reg    = '0;
		x_lo     = '0;
		x_hi     = '0;
		result   = '0;

		if (item.operation) begin
			// Bus status event
			unique case (item.bus_status)
				ST_START, ST_RSTART: begin
					result.start_clear = 1'b1;
					result.tx_valid    = 1'b1;
					result.tx_byte     = device_q;
				end
				ST_SLAW_ACK: begin
					result.tx_valid = 1'b1;
					result.tx_byte  = target_q;
				end
				ST_DATA_ACK: begin
					bcount_d = bcount_inc;
					if (bcount_inc == 8'd1) begin
						result.tx_valid = 1'b1;
						result.tx_byte  = lo_q;
					end else if (bcount_inc == 8'd2) begin
						result.tx_valid = 1'b1;
						result.tx_byte  = hi_q;
					end else if (bcount_inc == 8'd3) begin
						result.stop_request = 1'b1;
						busy_d = 1'b0;
					end else begin
						// register address sent for a read: repeated start with read bit
						result.start_request = 1'b1;
						device_d = {device_q[7:1], 1'b1};
					end
				end
				ST_SLAR_ACK: result.ack_control = ACK_SET;
				ST_RX_ACK: begin
					lo_d = item.read_byte;
					result.ack_control = ACK_CLEAR;
				end
				ST_RX_NACK: begin
					hi_d = item.read_byte;
					result.stop_request = 1'b1;
					busy_d = 1'b0;
				end
				ST_SLAW_NACK, ST_DATA_NACK, ST_SLAR_NACK: begin
					result.stop_request = 1'b1;
					busy_d = 1'b0;
				end
				default: ;
			endcase
		end else if (!busy_q) begin
			// Sequencer tick
			unique case (phase_q)
				PH_RECOVER: begin
					if (!(item.scl_level && item.sda_level))
						result.scl_drive = item.scl_level ? SCL_LOW : SCL_RELEASE;
				end
				PH_DELAY: begin
					if (!delay_done) begin
						delay_d = delay_q + 8'd1;
					end else begin
						begin_x = 1'b1;
						x_reg   = REG_RESET;
						x_lo    = RESET_CMD;
					end
				end
				PH_INIT_CTRL: begin
					begin_x = 1'b1;
					x_reg   = REG_CONTROL;
					x_lo    = cfg_q.control_word[7:0];
					x_hi    = cfg_q.control_word[15:8];
				end
				PH_INIT_ILIM: begin
					begin_x = 1'b1;
					x_reg   = REG_ILIM_MAX;
					x_lo    = cfg_q.current_limit_max[7:0];
					x_hi    = cfg_q.current_limit_max[15:8];
				end
				PH_INIT_UV: begin
					begin_x = 1'b1;
					x_reg   = REG_UVLO;
					x_hi    = cfg_q.undervoltage_threshold;
				end
				PH_IDLE: begin
					wvolt_d = volt_calc;
					wcurr_d = curr_calc;
					begin_x = 1'b1;
					if (curr_diff) begin
						x_reg = REG_ILIM;
						x_lo  = curr_calc[7:0];
						x_hi  = curr_calc[15:8];
					end else if (volt_diff) begin
						x_reg = REG_VOUT;
						x_lo  = volt_calc[7:0];
						x_hi  = volt_calc[15:8];
					end else begin
						x_reg = REG_STATUS;
						x_lo  = lo_q;
						x_hi  = hi_q;
					end
				end
				PH_VOLT_SENT: svolt_d = wvolt_q;
				PH_CURR_SENT: scurr_d = wcurr_q;
				PH_STAT_READ: status_d = hi_q;
				default: ;
			endcase
		end

		// Transfer launch
		if (begin_x) begin
			target_d = x_reg;
			lo_d     = x_lo;
			hi_d     = x_hi;
			bcount_d = (phase_d == PH_STAT_READ) ? BYTE_CNT_RD : 8'd0;
			device_d = {cfg_q.slave_address, 1'b0};
			busy_d   = 1'b1;
			result.start_request = 1'b1;
		end

		result.busy_flag        = busy_d;
		result.converter_status = status_d;
		result.phase            = phase_d;
	end

	// State update, one item per cycle while step_en is high
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_RECOVER;
			delay_q  <= '0;
			busy_q   <= 1'b0;
			bcount_q <= '0;
			device_q <= '0;
			target_q <= '0;
			lo_q     <= '0;
			hi_q     <= '0;
			wvolt_q  <= '0;
			wcurr_q  <= '0;
			svolt_q  <= '0;
			scurr_q  <= '0;
			status_q <= '0;
		end else if (step_en) begin
			phase_q  <= phase_d;
			delay_q  <= delay_d;
			busy_q   <= busy_d;
			bcount_q <= bcount_d;
			device_q <= device_d;
			target_q <= target_d;
			lo_q     <= lo_d;
			hi_q     <= hi_d;
			wvolt_q  <= wvolt_d;
			wcurr_q  <= wcurr_d;
			svolt_q  <= svolt_d;
			scurr_q  <= scurr_d;
			status_q <= status_d;
		end
	end

endmodule

// File: rtl/i2c_register_sync_sequencer_unit.sv
// Top level: input stage, sequencer core and result register with stream handshakes.
//
// Usage
//   Slave stream (s_*): one item per transfer. s_tuser is the item kind
//   (0 sequencer tick, 1 I2C bus status event); s_tdata carries the status
//   code, data-register byte, requested voltage and current, the overcurrent
//   select and the sampled SCL/SDA levels.
//   Master stream (m_*): exactly one result per item, in order, carrying the
//   bus commands to the I2C controller plus busy flag, last converter status
//   and the sequencer phase after the step.
//   Config port: cfg_we/cfg_index/cfg_data, to be written only while idle; the block does not enforce this.
// Timing
//   An accepted item is registered in the input stage, stepped through the core
//   and its result registered in the result register that drives m_tvalid.
//   One item per cycle sustained while m_tready is high.
// Reset
//   arst_n clears both stages and puts the sequencer in bus recovery with all
//   configuration registers at their defaults.
// Back-pressure
//   While m_tready is low the result holds and one more item waits in the
//   input stage; s_tready drops only when both are full.
`timescale 1ns / 1ps

module i2c_register_sync_sequencer_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// [7:0] bus_status, [15:8] read_byte, [31:16] requested_voltage,
	// [47:32] requested_current, [48] overcurrent_enabled, [49] scl_level,
	// [50] sda_level, [55:51] zero
	input  logic [i2crs_pkg::DATA_IN_W-1:0]    s_tdata,
	// [0] operation
	input  logic                               s_tuser,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// [0] start_request, [1] start_clear, [2] stop_request, [4:3] ack_control,
	// [5] tx_valid, [13:6] tx_byte, [15:14] scl_drive, [16] busy_flag,
	// [24:17] converter_status, [28:25] phase, [31:29] zero
	output logic [i2crs_pkg::DATA_OUT_W-1:0]   m_tdata,
	input  logic                               cfg_we,
	input  logic [2:0]                         cfg_index,
	input  logic [15:0]                        cfg_data
);
	import i2crs_pkg::*;

	item_t   item_s1;
	logic    valid_s1;
	logic    advance;
	result_t step_res;
	result_t res_q;

	assign advance  = valid_s1 && (!m_tvalid || m_tready);
	assign s_tready = !valid_s1 || advance;

	// Input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.operation           <= s_tuser;
			item_s1.bus_status          <= s_tdata[7:0];
			item_s1.read_byte           <= s_tdata[15:8];
			item_s1.requested_voltage   <= s_tdata[31:16];
			item_s1.requested_current   <= s_tdata[47:32];
			item_s1.overcurrent_enabled <= s_tdata[48];
			item_s1.scl_level           <= s_tdata[49];
			item_s1.sda_level           <= s_tdata[50];
		end
	end

	// Sequencer core
	i2crs_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.step_en   (advance),
		.item      (item_s1),
		.result    (step_res)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (!m_tvalid || m_tready) begin
			m_tvalid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) res_q <= step_res;
	end

	assign m_tdata = {3'b000, res_q.phase, res_q.converter_status, res_q.busy_flag,
		res_q.scl_drive, res_q.tx_byte, res_q.tx_valid, res_q.ack_control,
		res_q.stop_request, res_q.start_clear, res_q.start_request};

	// Checks
	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (res_q.phase <= 4'd12))
		else $error("phase out of range");

	a_tx_byte_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !res_q.tx_valid) |-> (res_q.tx_byte == 8'd0))
		else $error("tx_byte set without tx_valid");

	a_start_stop: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(res_q.start_request && res_q.stop_request))
		else $error("start and stop in one result");

	a_stop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && res_q.stop_request) |-> !res_q.busy_flag)
		else $error("busy after stop");

	a_stage_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> (valid_s1 && $stable(item_s1)))
		else $error("input stage lost a stalled item");

endmodule
